/* rtl/cosine_similarity_stream_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the cosine similarity stream unit
// Expect clk and rst_n in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef COSINE_SIMILARITY_STREAM_UNIT_ASSERT_SVH
`define COSINE_SIMILARITY_STREAM_UNIT_ASSERT_SVH

// same-cycle implication
`define CSSU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSSU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cssu_pkg.sv */
// ----------------------------------------------------------------------------
// cssu_pkg
// Shared types and constants of the cosine similarity stream unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cssu_pkg;

    localparam int ELEM_WIDTH      = 16;
    localparam int FRAC_BITS       = ELEM_WIDTH - 1;
    localparam int OUT_WIDTH       = 16;
    localparam int ACC_WIDTH_DEF   = 48;
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic signed [ELEM_WIDTH-1:0] a_elem;
        logic signed [ELEM_WIDTH-1:0] b_elem;
        logic                         last;
    } elem_beat_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] similarity;
        logic                        zero_magnitude;
    } result_beat_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

/* rtl/cssu_front.sv */
// ----------------------------------------------------------------------------
// cssu_front
// Multiply stage plus accumulate stage; pushes the totals on a last beat.
// ----------------------------------------------------------------------------
`default_nettype none

module cssu_front
    import cssu_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 elem_valid,
    output logic                      elem_stall,
    input  wire elem_beat_t           elem,
    input  wire q_status_t            q_status,
    output logic                      push,
    output logic [ACC_WIDTH-1:0]      push_dot,
    output logic [ACC_WIDTH-1:0]      push_sa,
    output logic [ACC_WIDTH-1:0]      push_sb
);

    localparam int PROD_W = 2 * ELEM_WIDTH;

    logic                     s1_valid_reg, s1_valid_next;
    logic                     s1_last_reg;
    logic signed [PROD_W-1:0] prod_ab_reg, prod_aa_reg, prod_bb_reg;
    logic [ACC_WIDTH-1:0]     dot_acc_reg, dot_acc_next;
    logic [ACC_WIDTH-1:0]     sumsq_a_reg, sumsq_a_next;
    logic [ACC_WIDTH-1:0]     sumsq_b_reg, sumsq_b_next;
    logic                     hold;
    logic                     accept;
    logic                     s1_fire;

    // a last beat waits in stage 1 until the queue has room
    assign hold       = s1_valid_reg && s1_last_reg && q_status.full;
    assign elem_stall = hold;
    assign accept     = elem_valid && !hold;
    assign s1_fire    = s1_valid_reg && !hold;

    assign push_dot = dot_acc_reg + ACC_WIDTH'(prod_ab_reg);
    assign push_sa  = sumsq_a_reg + ACC_WIDTH'(prod_aa_reg);
    assign push_sb  = sumsq_b_reg + ACC_WIDTH'(prod_bb_reg);
    assign push     = s1_fire && s1_last_reg;

    always_comb
    begin
        s1_valid_next = hold ? s1_valid_reg : accept;
        dot_acc_next  = dot_acc_reg;
        sumsq_a_next  = sumsq_a_reg;
        sumsq_b_next  = sumsq_b_reg;
        if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                dot_acc_next = '0;
                sumsq_a_next = '0;
                sumsq_b_next = '0;
            end
            else
            begin
                dot_acc_next = push_dot;
                sumsq_a_next = push_sa;
                sumsq_b_next = push_sb;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            dot_acc_reg  <= '0;
            sumsq_a_reg  <= '0;
            sumsq_b_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            dot_acc_reg  <= dot_acc_next;
            sumsq_a_reg  <= sumsq_a_next;
            sumsq_b_reg  <= sumsq_b_next;
            if (accept)
            begin
                s1_last_reg <= elem.last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_ab_reg <= elem.a_elem * elem.b_elem;
            prod_aa_reg <= elem.a_elem * elem.a_elem;
            prod_bb_reg <= elem.b_elem * elem.b_elem;
        end
    end

endmodule

`default_nettype wire

/* rtl/cssu_queue.sv */
// ----------------------------------------------------------------------------
// cssu_queue
// Small register queue of per-vector totals between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module cssu_queue
    import cssu_pkg::*;
#(
    parameter int WIDTH = 3 * ACC_WIDTH_DEF,
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rd_data,
    output q_status_t             q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign rd_data        = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/cssu_back.sv */
// ----------------------------------------------------------------------------
// cssu_back
// Per-vector sequencer: two bitwise square roots, one multiply, a
// restoring divide, saturation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cssu_back
    import cssu_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire q_status_t            q_status,
    input  wire logic [ACC_WIDTH-1:0] q_dot,
    input  wire logic [ACC_WIDTH-1:0] q_sa,
    input  wire logic [ACC_WIDTH-1:0] q_sb,
    output logic                      pop,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output result_beat_t              result
);

    localparam int SQW   = (ACC_WIDTH + 1) / 2;   // root width
    localparam int W2    = 2 * SQW;               // radicand / product width
    localparam int RW    = W2 + 1;                // remainder width
    localparam int QW    = FRAC_BITS + 1;         // quotient bits
    localparam int CNT_W = $clog2(SQW + 1);

    localparam logic [W2-1:0] PROBE_INIT = W2'(1) << (W2 - 2);
    localparam logic [QW-1:0] LIMIT_POS  = QW'((1 << FRAC_BITS) - 1);
    localparam logic [QW-1:0] LIMIT_NEG  = QW'(1 << FRAC_BITS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROOT = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_PREP = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]           state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [W2-1:0]        xa_reg, xb_reg, ra_reg, rb_reg, probe_reg;
    logic [ACC_WIDTH-1:0] dot_reg;
    logic [W2-1:0]        prod_reg;
    logic [RW-1:0]        rem_reg;
    logic [QW-1:0]        quo_reg;
    logic                 neg_reg, sat_reg, zero_reg;
    logic                 result_valid_reg;
    result_beat_t         result_reg;

    logic [2*W2-1:0]      step_a, step_b;
    logic [ACC_WIDTH-1:0] mag;
    logic                 div_ge;
    logic [RW-1:0]        div_sub;
    logic                 out_free;
    logic [QW-1:0]        sim;
    result_beat_t         result_next;

    // one digit of the shift-subtract square root; returns {x, r}
    function automatic logic [2*W2-1:0] root_step(
        input logic [W2-1:0] x,
        input logic [W2-1:0] r,
        input logic [W2-1:0] probe
    );
        logic [W2:0]   trial;
        logic [W2-1:0] x_n;
        logic [W2-1:0] r_n;
        trial = {1'b0, r} + {1'b0, probe};
        if ({1'b0, x} >= trial)
        begin
            x_n = x - trial[W2-1:0];
            r_n = (r >> 1) + probe;
        end
        else
        begin
            x_n = x;
            r_n = r >> 1;
        end
        return {x_n, r_n};
    endfunction

    assign step_a   = root_step(xa_reg, ra_reg, probe_reg);
    assign step_b   = root_step(xb_reg, rb_reg, probe_reg);
    assign mag      = dot_reg[ACC_WIDTH-1] ? (ACC_WIDTH'(0) - dot_reg) : dot_reg;
    assign div_ge   = rem_reg >= RW'(prod_reg);
    assign div_sub  = div_ge ? (rem_reg - RW'(prod_reg)) : rem_reg;
    assign out_free = !result_valid_reg || !result_stall;
    assign pop      = (state_reg == ST_IDLE) && !q_status.empty;

    always_comb
    begin
        if (sat_reg)
        begin
            sim = neg_reg ? LIMIT_NEG : LIMIT_POS;
        end
        else if (neg_reg)
        begin
            sim = (quo_reg > LIMIT_NEG) ? LIMIT_NEG : quo_reg;
        end
        else
        begin
            sim = (quo_reg > LIMIT_POS) ? LIMIT_POS : quo_reg;
        end
        if (zero_reg)
        begin
            result_next.similarity     = '0;
            result_next.zero_magnitude = 1'b1;
        end
        else
        begin
            result_next.similarity     = neg_reg ? OUT_WIDTH'(QW'(0) - sim) : OUT_WIDTH'(sim);
            result_next.zero_magnitude = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // a new beat may replace the one leaving in the same cycle
            if ((state_reg == ST_FIN) && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_status.empty)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(SQW - 1))
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_PREP;
                end
                ST_PREP:
                begin
                    cnt_reg   <= '0;
                    state_reg <= (prod_reg == '0) ? ST_FIN : ST_DIV;
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(QW - 1))
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                xa_reg    <= W2'(q_sa);
                xb_reg    <= W2'(q_sb);
                dot_reg   <= q_dot;
                ra_reg    <= '0;
                rb_reg    <= '0;
                probe_reg <= PROBE_INIT;
            end
            ST_ROOT:
            begin
                {xa_reg, ra_reg} <= step_a;
                {xb_reg, rb_reg} <= step_b;
                probe_reg        <= probe_reg >> 2;
            end
            ST_MUL:
            begin
                prod_reg <= ra_reg[SQW-1:0] * rb_reg[SQW-1:0];
            end
            ST_PREP:
            begin
                zero_reg <= (prod_reg == '0);
                neg_reg  <= dot_reg[ACC_WIDTH-1];
                rem_reg  <= RW'(mag);
                sat_reg  <= RW'(mag) >= {prod_reg, 1'b0};
                quo_reg  <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= {div_sub[W2-1:0], 1'b0};
                quo_reg <= {quo_reg[QW-2:0], div_ge};
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    result_reg <= result_next;
                end
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

/* rtl/cosine_similarity_stream_unit.sv */
// ----------------------------------------------------------------------------
// Throughput: one element pair per cycle, except while a last beat waits
//   in stage 1 on a full queue; the back end takes one vector at a time,
//   with one-bit-per-cycle roots and divide.
// Reset: rst_n clears accumulators, queue and sequencer; no clearing pass.
// ----------------------------------------------------------------------------
// cosine_similarity_stream_unit
// Streaming cosine similarity of two Q1.15 vectors, one pair per beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cosine_similarity_stream_unit_assert.svh"

module cosine_similarity_stream_unit
    import cssu_pkg::*;
#(
    parameter int ACC_WIDTH   = ACC_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         elem_valid,
    output logic              elem_stall,
    input  wire elem_beat_t   elem,
    output logic              result_valid,
    input  wire logic         result_stall,
    output result_beat_t      result
);

    // Front end: a multiply stage and an accumulate stage. Dot product and
    // both sums of squares wrap modulo 2^ACC_WIDTH. The last beat of a
    // vector pushes the three totals into the queue and clears the sums.
    // The front only stalls when a last beat meets a full queue.

    // Back end: pops one set of totals, runs both floor square roots in
    // parallel (one digit per cycle), multiplies the roots, then a restoring
    // divide yields one integer bit plus FRAC_BITS fraction bits of
    // |dot| * 2^FRAC_BITS / (ra * rb). A quotient of two or more, or one past
    // the Q1.15 limit, saturates. A zero product reports zero_magnitude.
    // The result register frees the sequencer to start the next vector.

    localparam int Q_WIDTH = 3 * ACC_WIDTH;

    q_status_t            q_status;
    logic                 q_push;
    logic                 q_pop;
    logic [ACC_WIDTH-1:0] push_dot, push_sa, push_sb;
    logic [Q_WIDTH-1:0]   q_rd_data;

    cssu_front #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .elem_valid (elem_valid),
        .elem_stall (elem_stall),
        .elem       (elem),
        .q_status   (q_status),
        .push       (q_push),
        .push_dot   (push_dot),
        .push_sa    (push_sa),
        .push_sb    (push_sb)
    );

    cssu_queue #(
        .WIDTH (Q_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_data  ({push_dot, push_sa, push_sb}),
        .pop      (q_pop),
        .rd_data  (q_rd_data),
        .q_status (q_status)
    );

    cssu_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .q_dot        (q_rd_data[3*ACC_WIDTH-1:2*ACC_WIDTH]),
        .q_sa         (q_rd_data[2*ACC_WIDTH-1:ACC_WIDTH]),
        .q_sb         (q_rd_data[ACC_WIDTH-1:0]),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `CSSU_ASSERT_IMP(a_no_push_full, q_push, !q_status.full, "push into full queue")
    `CSSU_ASSERT_IMP(a_q_flags, 1'b1, !(q_status.full && q_status.empty), "queue full and empty")
    `CSSU_ASSERT_IMP(a_stall_cause, elem_stall, q_status.full, "front stall without full queue")
    `CSSU_ASSERT_IMP(a_zero_sim, result_valid && result.zero_magnitude, result.similarity == '0, "zero magnitude with nonzero similarity")
    `CSSU_ASSERT_NXT(a_push_lands, q_push && !q_pop, !q_status.empty, "pushed entry lost")

endmodule

`default_nettype wire
